// ===== rtl/core/sbu_pkg.sv =====
// shared constants for the seven-bit to byte unpacker
package sbu_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned DataW   = 7;
  localparam int unsigned PosW    = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ResyncW = 16;

  localparam logic [PosW-1:0]    PosStart  = 3'd0;
  localparam logic [PosW-1:0]    PosLast   = 3'd7;
  localparam logic [ResyncW-1:0] ResyncMax = 16'hFFFF;

  typedef logic [CharW-1:0]   char_t;
  typedef logic [DataW-1:0]   data_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [ResyncW-1:0] resync_t;

endpackage

// ===== rtl/core/sbu_char_if.sv =====
// valid/ready channel carrying one received character per beat
interface sbu_char_if;
  import sbu_pkg::*;

  logic  valid;
  logic  ready;
  char_t in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

// ===== rtl/core/sbu_byte_if.sv =====
// valid/ready channel carrying one reassembled byte and the resync total per beat
interface sbu_byte_if;
  import sbu_pkg::*;

  logic    valid;
  logic    ready;
  byte_t   data_byte;
  resync_t resync_total;

  modport source (output valid, output data_byte, output resync_total, input ready);
  modport sink   (input valid, input data_byte, input resync_total, output ready);
endinterface

// ===== rtl/core/seven_bit_to_byte_unpacker.sv =====
// top level of the seven-bit to byte unpacker
//
//  channel   dir   payload                     beat
//  in_i      in    in_char                     one character
//  out_o     out   data_byte, resync_total     one byte
//
// one character per cycle sustained while the output is not stalled
// a character is registered, then decoded against group state into the output register
// a character that yields no byte retires even while the output is stalled
// reset clears group position, carry bits, resync count and all valid flags
module seven_bit_to_byte_unpacker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbu_char_if.sink    in_i,
  sbu_byte_if.source  out_o
);
  import sbu_pkg::*;

  logic    in_vld_q;
  char_t   in_char_q;
  pos_t    pos_q, pos_d;
  data_t   carry_q, carry_d;
  resync_t resync_q, resync_d;
  logic    out_vld_q, out_vld_d;
  byte_t   byte_q, byte_d;
  resync_t out_resync_q, out_resync_d;

  logic    brk;
  logic    has_result;
  logic    out_free;
  logic    s1_fire;
  data_t   c7;
  byte_t   shifted;

  assign brk        = in_char_q[CharW-1];
  assign c7         = in_char_q[DataW-1:0];
  assign has_result = !brk && (pos_q != PosStart);
  assign out_free   = !out_vld_q || out_o.ready;
  assign s1_fire    = in_vld_q && (out_free || !has_result);
  assign in_i.ready = !in_vld_q || s1_fire;

  assign shifted = byte_t'({1'b0, c7} << (4'd8 - {1'b0, pos_q}));

  always_comb begin
    pos_d        = pos_q;
    carry_d      = carry_q;
    resync_d     = resync_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    byte_d       = byte_q;
    out_resync_d = out_resync_q;
    if (s1_fire) begin
      if (brk) begin
        pos_d   = PosStart;
        carry_d = '0;
        if (resync_q != ResyncMax) begin
          resync_d = resync_q + resync_t'(1);
        end
      end else if (pos_q == PosStart) begin
        carry_d = c7;
        pos_d   = pos_t'(1);
      end else begin
        byte_d       = {1'b0, carry_q} | shifted;
        out_resync_d = resync_q;
        out_vld_d    = 1'b1;
        if (pos_q == PosLast) begin
          pos_d   = PosStart;
          carry_d = '0;
        end else begin
          pos_d   = pos_q + pos_t'(1);
          carry_d = c7 >> pos_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pos_q     <= PosStart;
      carry_q   <= '0;
      resync_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      pos_q     <= pos_d;
      carry_q   <= carry_d;
      resync_q  <= resync_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.in_char;
    end
    byte_q       <= byte_d;
    out_resync_q <= out_resync_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.data_byte    = byte_q;
  assign out_o.resync_total = out_resync_q;

endmodule

// ===== rtl/core/sbu_checker.sv =====
// port-level checks for the seven-bit to byte unpacker and their bind
module sbu_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [7:0]            out_data_byte_i,
  input logic [15:0]           out_resync_total_i
);
  import sbu_pkg::*;

  resync_t last_resync_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_resync_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      last_resync_q <= out_resync_total_i;
    end
  end

  // stalled byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_byte_i)
      && $stable(out_resync_total_i))
    else $error("stalled output beat changed");

  // resync total never goes down between bytes
  a_resync_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_resync_total_i >= last_resync_q)
    else $error("resync total decreased");

  // an empty output register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // a waiting input beat is held back only by a stalled byte
  a_ready_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input blocked without a stalled byte");

endmodule

bind seven_bit_to_byte_unpacker sbu_checker u_sbu_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_data_byte_i    (out_o.data_byte),
  .out_resync_total_i (out_o.resync_total)
);
